/* src/bad_pkg.sv */
// Shared constants and types of the box area downsampler.
package bad_pkg;

  localparam int MAX_DST_WIDTH = 1024;
  localparam int CHANNEL_BITS  = 16;
  localparam int SRC_MAX       = 4096;

  localparam int SIZE_BITS  = 13;                      // holds 1..4096
  localparam int POS_BITS   = 12;                      // holds 0..4095
  localparam int DCOL_BITS  = $clog2(MAX_DST_WIDTH);
  localparam int AREA_BITS  = 2 * POS_BITS + 1;        // up to 4096*4096
  localparam int ACC_BITS   = 2 * POS_BITS + CHANNEL_BITS;
  localparam int REM_BITS   = AREA_BITS + 1;
  localparam int DCNT_BITS  = $clog2(CHANNEL_BITS + 1);
  localparam int LINE_WIDTH = 3 * ACC_BITS;

  localparam logic [12:0] RST_SRC_W = 13'd1024;
  localparam logic [12:0] RST_SRC_H = 13'd1024;
  localparam logic [10:0] RST_DST_W = 11'd512;
  localparam logic [12:0] RST_DST_H = 13'd512;

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_idx_e;

endpackage

/* src/box_area_downsampler.sv */
// Area-average downsampler: source pixels in raster order, one averaged result per box.
// Source pixels are taken one per clock while no mean is being computed or waiting
// for the output and no restart is pending. The last pixel of a box starts a restoring
// divider that yields CHANNEL_BITS quotient bits, one per cycle, for all three channels
// at once; input is held off until the mean has been moved into the output register.
// Column sums live in one line RAM that is read and written back per pixel, with
// forwarding for back-to-back pixels of the same band. Band edges follow floor(k*src/dst)
// through exact error terms. A register write sets a registered restart that returns the
// frame to the top-left pixel.
module box_area_downsampler
  import bad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: red_in[15:0], green_in[31:16], blue_in[47:32]
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,
  // m_axis_tdata: red_out[15:0], green_out[31:16], blue_out[47:32],
  //   out_x[57:48], out_y[69:58], zero[71:70]; m_axis_tlast: frame_done
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [12:0] sw_q, sh_q, dh_q;
  logic [10:0] dw_q;
  logic        restart_q;
  logic [SIZE_BITS-1:0] eff_sw, eff_sh, eff_dw, eff_dh, dw_hi;
  reg_idx_e    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_SRC_W: prdata = {19'd0, sw_q};
      REG_SRC_H: prdata = {19'd0, sh_q};
      REG_DST_W: prdata = {21'd0, dw_q};
      REG_DST_H: prdata = {19'd0, dh_q};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q      <= RST_SRC_W;
      sh_q      <= RST_SRC_H;
      dw_q      <= RST_DST_W;
      dh_q      <= RST_DST_H;
      restart_q <= 1'b0;
    end else begin
      restart_q <= cfg_wr;
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_SRC_W: sw_q <= pwdata[12:0];
          REG_SRC_H: sh_q <= pwdata[12:0];
          REG_DST_W: dw_q <= pwdata[10:0];
          REG_DST_H: dh_q <= pwdata[12:0];
          default:   sw_q <= sw_q;
        endcase
      end
    end
  end

  always_comb begin
    logic [SIZE_BITS-1:0] dwv;
    dwv = {2'b00, dw_q};
    if (sw_q == '0) eff_sw = SIZE_BITS'(1);
    else if (sw_q > SIZE_BITS'(SRC_MAX)) eff_sw = SIZE_BITS'(SRC_MAX);
    else eff_sw = sw_q;
    if (sh_q == '0) eff_sh = SIZE_BITS'(1);
    else if (sh_q > SIZE_BITS'(SRC_MAX)) eff_sh = SIZE_BITS'(SRC_MAX);
    else eff_sh = sh_q;
    dw_hi = (eff_sw > SIZE_BITS'(MAX_DST_WIDTH)) ? SIZE_BITS'(MAX_DST_WIDTH) : eff_sw;
    if (dwv == '0) eff_dw = SIZE_BITS'(1);
    else if (dwv > dw_hi) eff_dw = dw_hi;
    else eff_dw = dwv;
    if (dh_q == '0) eff_dh = SIZE_BITS'(1);
    else if (dh_q > eff_sh) eff_dh = eff_sh;
    else eff_dh = dh_q;
  end

  // raster position and band tracking
  logic [POS_BITS-1:0]  src_col_q, src_row_q, dst_row_q, col_start_q, row_start_q;
  logic [POS_BITS-1:0]  src_col_d, src_row_d, dst_row_d, col_start_d, row_start_d;
  logic [DCOL_BITS-1:0] dst_col_q, dst_col_d;
  logic [SIZE_BITS-1:0] col_err_q, row_err_q, col_err_d, row_err_d;

  logic s1_valid_q, s1_emit_q, div_busy_q;
  logic in_accept, last_col, last_row, first_row, row_end, frame_end, frame_last;
  logic [SIZE_BITS-1:0] col_plus, row_plus, band_w, band_h;

  assign s_axis_tready_o = !restart_q && !div_busy_q && !(s1_valid_q && s1_emit_q);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  assign col_plus  = {1'b0, src_col_q} + SIZE_BITS'(1);
  assign row_plus  = {1'b0, src_row_q} + SIZE_BITS'(1);
  assign last_col  = col_err_q < eff_dw;
  assign last_row  = row_err_q < eff_dh;
  assign first_row = src_row_q == row_start_q;
  assign row_end   = col_plus >= eff_sw;
  assign frame_end = row_plus >= eff_sh;
  assign band_w    = col_plus - {1'b0, col_start_q};
  assign band_h    = row_plus - {1'b0, row_start_q};
  assign frame_last = (SIZE_BITS'(dst_col_q) + SIZE_BITS'(1) == eff_dw) &&
                      ({1'b0, dst_row_q} + SIZE_BITS'(1) == eff_dh);

  always_comb begin
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    dst_col_d   = dst_col_q;
    dst_row_d   = dst_row_q;
    col_start_d = col_start_q;
    row_start_d = row_start_q;
    col_err_d   = col_err_q;
    row_err_d   = row_err_q;
    if (restart_q) begin
      src_col_d   = '0;
      src_row_d   = '0;
      dst_col_d   = '0;
      dst_row_d   = '0;
      col_start_d = '0;
      row_start_d = '0;
      col_err_d   = eff_sw - eff_dw;
      row_err_d   = eff_sh - eff_dh;
    end else if (in_accept) begin
      src_col_d = src_col_q + POS_BITS'(1);
      if (last_col) begin
        col_start_d = col_plus[POS_BITS-1:0];
        dst_col_d   = dst_col_q + DCOL_BITS'(1);
        col_err_d   = col_err_q - eff_dw + eff_sw;
      end else begin
        col_err_d   = col_err_q - eff_dw;
      end
      if (row_end) begin
        src_col_d   = '0;
        dst_col_d   = '0;
        col_start_d = '0;
        col_err_d   = eff_sw - eff_dw;
        src_row_d   = src_row_q + POS_BITS'(1);
        if (last_row) begin
          row_start_d = row_plus[POS_BITS-1:0];
          dst_row_d   = dst_row_q + POS_BITS'(1);
          row_err_d   = row_err_q - eff_dh + eff_sh;
        end else begin
          row_err_d   = row_err_q - eff_dh;
        end
        if (frame_end) begin
          src_row_d   = '0;
          dst_row_d   = '0;
          row_start_d = '0;
          row_err_d   = eff_sh - eff_dh;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q   <= '0;
      src_row_q   <= '0;
      dst_col_q   <= '0;
      dst_row_q   <= '0;
      col_start_q <= '0;
      row_start_q <= '0;
      col_err_q   <= RST_SRC_W - {2'b00, RST_DST_W};
      row_err_q   <= RST_SRC_H - RST_DST_H;
    end else begin
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      dst_col_q   <= dst_col_d;
      dst_row_q   <= dst_row_d;
      col_start_q <= col_start_d;
      row_start_q <= row_start_d;
      col_err_q   <= col_err_d;
      row_err_q   <= row_err_d;
    end
  end

  // line store read-modify-write
  logic [CHANNEL_BITS-1:0] pix [3];
  logic [CHANNEL_BITS-1:0] s1_pix_q [3];
  logic [LINE_WIDTH-1:0]   rdata, wdata, s1_fwd_data_q;
  logic [DCOL_BITS-1:0]    s1_idx_q;
  logic                    s1_first_q, s1_fwd_q, s1_last_q;
  logic [SIZE_BITS-1:0]    s1_w_q, s1_h_q;
  logic [DCOL_BITS-1:0]    s1_x_q;
  logic [POS_BITS-1:0]     s1_y_q;

  always_comb begin
    logic [31:0] t;
    for (int c = 0; c < 3; c++) begin
      t = 32'(s_axis_tdata_i[16*c +: 16]);
      pix[c] = t[CHANNEL_BITS-1:0];
    end
  end

  always_comb begin
    logic [ACC_BITS-1:0] base;
    for (int c = 0; c < 3; c++) begin
      if (s1_first_q) base = '0;
      else if (s1_fwd_q) base = s1_fwd_data_q[ACC_BITS*c +: ACC_BITS];
      else base = rdata[ACC_BITS*c +: ACC_BITS];
      wdata[ACC_BITS*c +: ACC_BITS] = base + ACC_BITS'(s1_pix_q[c]);
    end
  end

  bad_ram #(
    .WIDTH(LINE_WIDTH),
    .DEPTH(MAX_DST_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_idx_q),
    .wdata_i (wdata),
    .re_i    (in_accept),
    .raddr_i (dst_col_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      s1_emit_q  <= in_accept && last_col && last_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q      <= pix;
      s1_idx_q      <= dst_col_q;
      s1_first_q    <= first_row;
      // the RAM misses a write to the same entry at this edge
      s1_fwd_q      <= s1_valid_q && (s1_idx_q == dst_col_q);
      s1_fwd_data_q <= wdata;
      s1_w_q        <= band_w;
      s1_h_q        <= band_h;
      s1_x_q        <= dst_col_q;
      s1_y_q        <= dst_row_q;
      s1_last_q     <= frame_last;
    end
  end

  // mean divider: restoring, one quotient bit per cycle per channel
  logic [DCNT_BITS-1:0]    div_cnt_q;
  logic [REM_BITS-1:0]     rem_q [3];
  logic [CHANNEL_BITS-1:0] quo_q [3];
  logic [AREA_BITS-1:0]    den_q, area;
  logic [DCOL_BITS-1:0]    div_x_q;
  logic [POS_BITS-1:0]     div_y_q;
  logic                    div_last_q, div_load, div_done, m_valid_q;

  assign area     = AREA_BITS'(s1_w_q * s1_h_q);
  assign div_load = s1_valid_q && s1_emit_q;
  assign div_done = div_busy_q && (div_cnt_q == '0) && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (div_load) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= DCNT_BITS'(CHANNEL_BITS);
      end else if (div_done) begin
        div_busy_q <= 1'b0;
      end else if (div_busy_q && div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - DCNT_BITS'(1);
      end
      if (div_done) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [REM_BITS-1:0] sh;
    if (div_load) begin
      den_q      <= area;
      div_x_q    <= s1_x_q;
      div_y_q    <= s1_y_q;
      div_last_q <= s1_last_q;
      for (int c = 0; c < 3; c++) begin
        // the high part is below the area since the mean fits CHANNEL_BITS
        rem_q[c] <= REM_BITS'(wdata[ACC_BITS*c + CHANNEL_BITS +: ACC_BITS - CHANNEL_BITS]);
        quo_q[c] <= wdata[ACC_BITS*c +: CHANNEL_BITS];
      end
    end else if (div_busy_q && div_cnt_q != '0) begin
      for (int c = 0; c < 3; c++) begin
        sh = {rem_q[c][REM_BITS-2:0], quo_q[c][CHANNEL_BITS-1]};
        if (sh >= {1'b0, den_q}) begin
          rem_q[c] <= sh - {1'b0, den_q};
          quo_q[c] <= {quo_q[c][CHANNEL_BITS-2:0], 1'b1};
        end else begin
          rem_q[c] <= sh;
          quo_q[c] <= {quo_q[c][CHANNEL_BITS-2:0], 1'b0};
        end
      end
    end
  end

  logic [71:0] m_data_q;
  logic        m_last_q;

  always_ff @(posedge clk_i) begin
    logic [31:0] t;
    if (div_done) begin
      for (int c = 0; c < 3; c++) begin
        t = 32'(quo_q[c]);
        m_data_q[16*c +: 16] <= t[15:0];
      end
      t = 32'(div_x_q);
      m_data_q[57:48] <= t[9:0];
      m_data_q[69:58] <= div_y_q;
      m_data_q[71:70] <= 2'b00;
      m_last_q        <= div_last_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* src/bad_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* src/bad_checker.sv */
// Port-level checks of the box area downsampler, bound to the top level.
module bad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        pready
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable({m_axis_tlast_o, m_axis_tdata_o}))
    else $error("stalled result changed");

  // handshake outputs are always driven once out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({m_axis_tvalid_o, s_axis_tready_o}))
    else $error("handshake output unknown");

  // a new result appears only while input is held off by the divider
  a_rise_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result without divider stall");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind box_area_downsampler bad_checker u_bad_checker (.*);
